>>> src/pkhc_pkg.sv
// ----------------------------------------------------------------------------
// pkhc_pkg: shared types and constants of the pair-key hash cache
// Field widths, command and status codes, hash constants, probe uses,
// sequencer states, result bundle.
`default_nettype none

package pkhc_pkg;

    localparam int CMD_W    = 2;
    localparam int BODY_W   = 32;
    localparam int TICK_W   = 32;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int ESLOT_W  = 7;
    localparam int CNT_W    = 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STS_INS  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd3;

    // splitmix64 finalizer multipliers
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // what a probe is run for
    typedef enum logic [1:0] {
        PU_LOOKUP,
        PU_REMOVE,
        PU_REPOINT
    } t_probe_use;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HWAIT,
        S_PCHK,
        S_PRDS,
        S_PRDK,
        S_EXTEST,
        S_EXAGE,
        S_EXKEY,
        S_SHCHK,
        S_SHRDS,
        S_SHRDK,
        S_SHHASH,
        S_POSTRM,
        S_RPKEY,
        S_RPTICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ESLOT_W-1:0]  entry_slot;
        logic [CNT_W-1:0]    removed_total;
        logic [CNT_W-1:0]    live_count;
    } t_result;

endpackage

`default_nettype wire

>>> src/pkhc_in_if.sv
// ----------------------------------------------------------------------------
// pkhc_in_if: command channel
// Valid/ready channel carrying one cache command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkhc_in_if;
    logic                                valid;
    logic                                ready;
    logic [pkhc_pkg::CMD_W-1:0]          cmd;
    logic [pkhc_pkg::BODY_W-1:0]         body_first;
    logic [pkhc_pkg::BODY_W-1:0]         body_second;
    logic [pkhc_pkg::TICK_W-1:0]         tick_now;

    modport source (output valid, cmd, body_first, body_second, tick_now, input ready);
    modport sink   (input valid, cmd, body_first, body_second, tick_now, output ready);
endinterface

`default_nettype wire

>>> src/pkhc_out_if.sv
// ----------------------------------------------------------------------------
// pkhc_out_if: result channel
// Valid/ready channel carrying one command result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkhc_out_if;
    logic                                valid;
    logic                                ready;
    logic [pkhc_pkg::STATUS_W-1:0]       status;
    logic [pkhc_pkg::ESLOT_W-1:0]        entry_slot;
    logic [pkhc_pkg::CNT_W-1:0]          removed_total;
    logic [pkhc_pkg::CNT_W-1:0]          live_count;

    modport source (output valid, status, entry_slot, removed_total, live_count, input ready);
    modport sink   (input valid, status, entry_slot, removed_total, live_count, output ready);
endinterface

`default_nettype wire

>>> src/pair_key_hash_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// pair_key_hash_cache_with_expiry: body-pair cache with tick-based expiry
// Linear-probing slot table over a dense key/tick array.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries commands (touch, insert, expire) with a body pair and the
//   current tick; o_out returns exactly one result per command. i_cfg_we /
//   i_cfg_wdata write max_age; write it only while the block is idle.
// Sequence from accept to result valid:
//   touch/insert: hash the pair, then check, read slot and read key for each
//   probed slot; the hash unit with its single 32x32 multiplier and the
//   one-read-a-cycle slot and key memories set the pace.
//   expire: an age test per entry; each removed entry adds a key read, a
//   hash, a probe walk, a shift pass, and a repoint if it was not the last.
// Throughput: one command at a time; i_in.ready is high only when idle.
// A finished result sits in an output register, so the next command is taken
// while the receiver stalls; a second result waits until the first is taken.
// Reset (synchronous, active low) empties the table, clears the live count
// and sets max_age to 60; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_key_hash_cache_with_expiry #(
    parameter int TABLE_SLOTS    = 256,
    parameter int ENTRY_CAPACITY = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pkhc_pkg::TICK_W-1:0]  i_cfg_wdata,
    pkhc_in_if.sink                           i_in,
    pkhc_out_if.source                        o_out
);

    localparam int SW = $clog2(TABLE_SLOTS);

    logic [pkhc_pkg::TICK_W-1:0] r_max_age;
    logic                        r_out_valid;
    pkhc_pkg::t_result           r_out;

    logic                        w_idle;
    logic                        w_accept;
    logic                        w_res_valid;
    logic                        w_res_take;
    pkhc_pkg::t_result           w_res;
    logic                        w_hash_start;
    logic [pkhc_pkg::KEY_W-1:0]  w_hash_key;
    logic                        w_hash_done;
    logic [SW-1:0]               w_hash_home;

    assign i_in.ready = w_idle;
    assign w_accept   = i_in.valid && w_idle;
    assign w_res_take = !r_out_valid || o_out.ready;

    // hold the max_age register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= pkhc_pkg::TICK_W'(60);
        end else if (i_cfg_we) begin
            r_max_age <= i_cfg_wdata;
        end
    end

    // output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_take) r_out <= w_res;
    end

    pkhc_hash #(
        .SW (SW)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_hash_key),
        .o_done  (w_hash_done),
        .o_home  (w_hash_home)
    );

    pkhc_ctrl #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .ENTRY_CAPACITY (ENTRY_CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_cmd        (i_in.cmd),
        .i_first      (i_in.body_first),
        .i_second     (i_in.body_second),
        .i_now        (i_in.tick_now),
        .i_max_age    (r_max_age),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_take   (w_res_take),
        .o_hash_start (w_hash_start),
        .o_hash_key   (w_hash_key),
        .i_hash_done  (w_hash_done),
        .i_hash_home  (w_hash_home)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.entry_slot    = r_out.entry_slot;
    assign o_out.removed_total = r_out.removed_total;
    assign o_out.live_count    = r_out.live_count;

    // live count never exceeds the array capacity
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.live_count <= pkhc_pkg::CNT_W'(ENTRY_CAPACITY))
        else $error("live count above capacity");

    // removals are reported only with a plain expire result
    a_expire_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.removed_total != '0) |->
            (o_out.status == pkhc_pkg::STS_HIT && o_out.entry_slot == '0))
        else $error("removal count on a non-expire result");

    // a new command is never taken while the sequencer holds an unsent result
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !i_in.ready)
        else $error("command accepted during result handoff");

endmodule

`default_nettype wire

>>> src/pkhc_hash.sv
// ----------------------------------------------------------------------------
// pkhc_hash: iterative splitmix64 home-slot hash
// One 32x32 multiplier builds each 64-bit product from three partial
// products, for both multiplier constants of the finalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module pkhc_hash #(
    parameter int SW = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pkhc_pkg::KEY_W-1:0]  i_key,
    output logic                             o_done,
    output logic [SW-1:0]                    o_home
);

    logic [63:0] r_k;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [63:0] w_c;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_mul;
    logic [63:0] w_sum;
    logic [63:0] w_mix;

    // select operands for the shared multiplier
    always_comb begin
        w_c   = r_step[2] ? pkhc_pkg::MIX_C2 : pkhc_pkg::MIX_C1;
        w_a   = (r_step[1:0] == 2'd1) ? r_k[63:32] : r_k[31:0];
        w_b   = (r_step[1:0] == 2'd2) ? w_c[63:32] : w_c[31:0];
        w_mul = {32'd0, w_a} * {32'd0, w_b};
        w_sum = r_acc + {r_prod[31:0], 32'd0};
        w_mix = r_step[2] ? (w_sum ^ (w_sum >> pkhc_pkg::MIX_SH2))
                          : (w_sum ^ (w_sum >> pkhc_pkg::MIX_SH1));
    end

    // control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: accumulate partial products, apply xor-shifts
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k <= i_key ^ (i_key >> pkhc_pkg::MIX_SH0);
        end else if (r_busy) begin
            r_prod <= w_mul;
            unique case (r_step[1:0])
                2'd0: ;
                2'd1: r_acc <= r_prod;
                2'd2: r_acc <= w_sum;
                2'd3: r_k   <= w_mix;
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_k[SW-1:0];

endmodule

`default_nettype wire

>>> src/pkhc_ctrl.sv
// ----------------------------------------------------------------------------
// pkhc_ctrl: command sequencer with slot table and dense entry stores
// Walks probe chains, appends entries and runs expire sweeps with
// backward-shift deletion and swap-with-last compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pkhc_ctrl #(
    parameter int TABLE_SLOTS    = 256,
    parameter int ENTRY_CAPACITY = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pkhc_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [pkhc_pkg::BODY_W-1:0]   i_first,
    input  wire logic [pkhc_pkg::BODY_W-1:0]   i_second,
    input  wire logic [pkhc_pkg::TICK_W-1:0]   i_now,
    input  wire logic [pkhc_pkg::TICK_W-1:0]   i_max_age,
    output logic                               o_idle,
    output logic                               o_res_valid,
    output pkhc_pkg::t_result                  o_res,
    input  wire logic                          i_res_take,
    output logic                               o_hash_start,
    output logic [pkhc_pkg::KEY_W-1:0]         o_hash_key,
    input  wire logic                          i_hash_done,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] i_hash_home
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int EW = $clog2(ENTRY_CAPACITY);
    localparam int CW = $clog2(ENTRY_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(ENTRY_CAPACITY);

    pkhc_pkg::t_state r_state, n_state;
    pkhc_pkg::t_probe_use r_use;

    // memories
    logic [EW-1:0]               slot_mem [TABLE_SLOTS];
    logic [pkhc_pkg::KEY_W-1:0]  key_mem  [ENTRY_CAPACITY];
    logic [pkhc_pkg::TICK_W-1:0] tick_mem [ENTRY_CAPACITY];
    logic [TABLE_SLOTS-1:0]      r_valid;

    logic [EW-1:0]               r_slot_rd;
    logic [pkhc_pkg::KEY_W-1:0]  r_key_rd;
    logic [pkhc_pkg::TICK_W-1:0] r_tick_rd;

    // working registers
    logic [pkhc_pkg::CMD_W-1:0]    r_cmd;
    logic [pkhc_pkg::TICK_W-1:0]   r_now;
    logic [pkhc_pkg::KEY_W-1:0]    r_key;
    logic [pkhc_pkg::TICK_W-1:0]   r_tick_last;
    logic [SW-1:0]                 r_pos;
    logic [SW-1:0]                 r_gap;
    logic [SW-1:0]                 r_nxt;
    logic [EW-1:0]                 r_idx;
    logic [EW-1:0]                 r_eslot;
    logic [CW-1:0]                 r_i;
    logic [CW-1:0]                 r_live;
    logic [CW-1:0]                 r_removed;
    logic [pkhc_pkg::STATUS_W-1:0] r_status;

    // memory port controls
    logic                          w_slot_we;
    logic [SW-1:0]                 w_slot_wa;
    logic [EW-1:0]                 w_slot_wd;
    logic [SW-1:0]                 w_slot_ra;
    logic                          w_key_we;
    logic [EW-1:0]                 w_key_wa;
    logic [pkhc_pkg::KEY_W-1:0]    w_key_wd;
    logic [EW-1:0]                 w_key_ra;
    logic                          w_tick_we;
    logic [EW-1:0]                 w_tick_wa;
    logic [pkhc_pkg::TICK_W-1:0]   w_tick_wd;
    logic [EW-1:0]                 w_tick_ra;

    logic [pkhc_pkg::BODY_W-1:0]   w_small;
    logic [pkhc_pkg::BODY_W-1:0]   w_large;
    logic [pkhc_pkg::KEY_W-1:0]    w_pair;
    logic [CW-1:0]                 w_last;
    logic [pkhc_pkg::TICK_W-1:0]   w_age;
    logic                          w_old;
    logic                          w_move;
    logic                          w_key_eq;
    logic                          w_full;

    // derived values
    always_comb begin
        w_small  = (i_first < i_second) ? i_first : i_second;
        w_large  = (i_first < i_second) ? i_second : i_first;
        w_pair   = {w_small, w_large};
        w_last   = r_live - CW'(1);
        w_age    = r_now - r_tick_rd;
        w_old    = w_age > i_max_age;
        w_key_eq = r_key_rd == r_key;
        w_full   = r_live >= CAP;
        if (r_nxt >= r_gap) begin
            w_move = (i_hash_home <= r_gap) || (i_hash_home > r_nxt);
        end else begin
            w_move = (i_hash_home <= r_gap) && (i_hash_home > r_nxt);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkhc_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == pkhc_pkg::CMD_TOUCH || i_cmd == pkhc_pkg::CMD_INSERT) begin
                        n_state = pkhc_pkg::S_HWAIT;
                    end else if (i_cmd == pkhc_pkg::CMD_EXPIRE) begin
                        n_state = pkhc_pkg::S_EXTEST;
                    end else begin
                        n_state = pkhc_pkg::S_DONE;
                    end
                end
            end
            pkhc_pkg::S_HWAIT: if (i_hash_done) n_state = pkhc_pkg::S_PCHK;
            pkhc_pkg::S_PCHK: begin
                if (r_valid[r_pos]) begin
                    n_state = pkhc_pkg::S_PRDS;
                end else begin
                    priority case (r_use)
                        pkhc_pkg::PU_LOOKUP: n_state = pkhc_pkg::S_DONE;
                        pkhc_pkg::PU_REMOVE: n_state = pkhc_pkg::S_POSTRM;
                        default:             n_state = pkhc_pkg::S_EXTEST;
                    endcase
                end
            end
            pkhc_pkg::S_PRDS: n_state = pkhc_pkg::S_PRDK;
            pkhc_pkg::S_PRDK: begin
                if (w_key_eq) begin
                    priority case (r_use)
                        pkhc_pkg::PU_LOOKUP: n_state = pkhc_pkg::S_DONE;
                        pkhc_pkg::PU_REMOVE: n_state = pkhc_pkg::S_SHCHK;
                        default:             n_state = pkhc_pkg::S_EXTEST;
                    endcase
                end else begin
                    n_state = pkhc_pkg::S_PCHK;
                end
            end
            pkhc_pkg::S_EXTEST: n_state = (r_i < r_live) ? pkhc_pkg::S_EXAGE
                                                          : pkhc_pkg::S_DONE;
            pkhc_pkg::S_EXAGE:  n_state = w_old ? pkhc_pkg::S_EXKEY : pkhc_pkg::S_EXTEST;
            pkhc_pkg::S_EXKEY:  n_state = pkhc_pkg::S_HWAIT;
            pkhc_pkg::S_SHCHK:  n_state = r_valid[r_nxt] ? pkhc_pkg::S_SHRDS
                                                          : pkhc_pkg::S_POSTRM;
            pkhc_pkg::S_SHRDS:  n_state = pkhc_pkg::S_SHRDK;
            pkhc_pkg::S_SHRDK:  n_state = pkhc_pkg::S_SHHASH;
            pkhc_pkg::S_SHHASH: if (i_hash_done) n_state = pkhc_pkg::S_SHCHK;
            pkhc_pkg::S_POSTRM: n_state = (r_i != w_last) ? pkhc_pkg::S_RPKEY
                                                           : pkhc_pkg::S_EXTEST;
            pkhc_pkg::S_RPKEY:  n_state = pkhc_pkg::S_RPTICK;
            pkhc_pkg::S_RPTICK: n_state = pkhc_pkg::S_HWAIT;
            pkhc_pkg::S_DONE:   if (i_res_take) n_state = pkhc_pkg::S_IDLE;
            default:            n_state = pkhc_pkg::S_IDLE;
        endcase
    end

    // outputs: memory ports and hash requests
    always_comb begin
        w_slot_we    = 1'b0;
        w_slot_wa    = r_pos;
        w_slot_wd    = r_live[EW-1:0];
        w_slot_ra    = r_pos;
        w_key_we     = 1'b0;
        w_key_wa     = r_live[EW-1:0];
        w_key_wd     = r_key;
        w_key_ra     = r_slot_rd;
        w_tick_we    = 1'b0;
        w_tick_wa    = r_live[EW-1:0];
        w_tick_wd    = r_now;
        w_tick_ra    = r_i[EW-1:0];
        o_hash_start = 1'b0;
        o_hash_key   = r_key;
        unique case (r_state)
            pkhc_pkg::S_IDLE: begin
                o_hash_key   = w_pair;
                o_hash_start = i_start &&
                    (i_cmd == pkhc_pkg::CMD_TOUCH || i_cmd == pkhc_pkg::CMD_INSERT);
            end
            pkhc_pkg::S_PCHK: begin
                // append on an insert miss unless the array is full
                if (!r_valid[r_pos] && r_use == pkhc_pkg::PU_LOOKUP &&
                    r_cmd == pkhc_pkg::CMD_INSERT && !w_full) begin
                    w_slot_we = 1'b1;
                    w_key_we  = 1'b1;
                    w_tick_we = 1'b1;
                end
            end
            pkhc_pkg::S_PRDK: begin
                if (w_key_eq && r_use == pkhc_pkg::PU_LOOKUP) begin
                    w_tick_we = 1'b1;
                    w_tick_wa = r_idx;
                end else if (w_key_eq && r_use == pkhc_pkg::PU_REPOINT) begin
                    // repoint the last entry and move it into the hole
                    w_slot_we = 1'b1;
                    w_slot_wd = r_i[EW-1:0];
                    w_key_we  = 1'b1;
                    w_key_wa  = r_i[EW-1:0];
                    w_tick_we = 1'b1;
                    w_tick_wa = r_i[EW-1:0];
                    w_tick_wd = r_tick_last;
                end
            end
            pkhc_pkg::S_EXAGE:  w_key_ra = r_i[EW-1:0];
            pkhc_pkg::S_EXKEY: begin
                o_hash_start = 1'b1;
                o_hash_key   = r_key_rd;
            end
            pkhc_pkg::S_SHCHK:  w_slot_ra = r_nxt;
            pkhc_pkg::S_SHRDK: begin
                o_hash_start = 1'b1;
                o_hash_key   = r_key_rd;
            end
            pkhc_pkg::S_SHHASH: begin
                if (i_hash_done && w_move) begin
                    w_slot_we = 1'b1;
                    w_slot_wa = r_gap;
                    w_slot_wd = r_idx;
                end
            end
            pkhc_pkg::S_POSTRM: w_key_ra  = w_last[EW-1:0];
            pkhc_pkg::S_RPKEY:  w_tick_ra = w_last[EW-1:0];
            pkhc_pkg::S_RPTICK: o_hash_start = 1'b1;
            default: ;
        endcase
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (w_slot_we) slot_mem[w_slot_wa] <= w_slot_wd;
        r_slot_rd <= slot_mem[w_slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) key_mem[w_key_wa] <= w_key_wd;
        r_key_rd <= key_mem[w_key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_we) tick_mem[w_tick_wa] <= w_tick_wd;
        r_tick_rd <= tick_mem[w_tick_ra];
    end

    // slot occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (r_state == pkhc_pkg::S_PCHK && w_slot_we) begin
                r_valid[r_pos] <= 1'b1;
            end
            if (r_state == pkhc_pkg::S_PRDK && w_key_eq && r_use == pkhc_pkg::PU_REMOVE) begin
                r_valid[r_pos] <= 1'b0;
            end
            if (r_state == pkhc_pkg::S_SHHASH && i_hash_done && w_move) begin
                r_valid[r_gap] <= 1'b1;
                r_valid[r_nxt] <= 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pkhc_pkg::S_IDLE;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pkhc_pkg::S_PCHK && w_slot_we) begin
                r_live <= r_live + CW'(1);
            end
            if ((r_state == pkhc_pkg::S_PRDK && w_key_eq && r_use == pkhc_pkg::PU_REPOINT) ||
                (r_state == pkhc_pkg::S_POSTRM && r_i == w_last)) begin
                r_live <= r_live - CW'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pkhc_pkg::S_IDLE: begin
                if (i_start) begin
                    r_cmd     <= i_cmd;
                    r_now     <= i_now;
                    r_key     <= w_pair;
                    r_use     <= pkhc_pkg::PU_LOOKUP;
                    r_i       <= '0;
                    r_removed <= '0;
                    r_status  <= pkhc_pkg::STS_HIT;
                    r_eslot   <= '0;
                end
            end
            pkhc_pkg::S_HWAIT: if (i_hash_done) r_pos <= i_hash_home;
            pkhc_pkg::S_PCHK: begin
                if (!r_valid[r_pos] && r_use == pkhc_pkg::PU_LOOKUP) begin
                    if (r_cmd == pkhc_pkg::CMD_TOUCH) begin
                        r_status <= pkhc_pkg::STS_MISS;
                    end else if (w_full) begin
                        r_status <= pkhc_pkg::STS_FULL;
                    end else begin
                        r_status <= pkhc_pkg::STS_INS;
                        r_eslot  <= r_live[EW-1:0];
                    end
                end
            end
            pkhc_pkg::S_PRDS: r_idx <= r_slot_rd;
            pkhc_pkg::S_PRDK: begin
                if (!w_key_eq) begin
                    r_pos <= r_pos + SW'(1);
                end else if (r_use == pkhc_pkg::PU_LOOKUP) begin
                    r_eslot <= r_idx;
                end else if (r_use == pkhc_pkg::PU_REMOVE) begin
                    r_gap <= r_pos;
                    r_nxt <= r_pos + SW'(1);
                end else begin
                    r_removed <= r_removed + CW'(1);
                end
            end
            pkhc_pkg::S_EXAGE: if (!w_old) r_i <= r_i + CW'(1);
            pkhc_pkg::S_EXKEY: begin
                r_key <= r_key_rd;
                r_use <= pkhc_pkg::PU_REMOVE;
            end
            pkhc_pkg::S_SHRDS: r_idx <= r_slot_rd;
            pkhc_pkg::S_SHHASH: begin
                if (i_hash_done) begin
                    if (w_move) r_gap <= r_nxt;
                    r_nxt <= r_nxt + SW'(1);
                end
            end
            pkhc_pkg::S_POSTRM: if (r_i == w_last) r_removed <= r_removed + CW'(1);
            pkhc_pkg::S_RPKEY:  r_key <= r_key_rd;
            pkhc_pkg::S_RPTICK: begin
                r_tick_last <= r_tick_rd;
                r_use       <= pkhc_pkg::PU_REPOINT;
            end
            default: ;
        endcase
    end

    assign o_idle      = r_state == pkhc_pkg::S_IDLE;
    assign o_res_valid = r_state == pkhc_pkg::S_DONE;
    assign o_res       = '{status:        r_status,
                           entry_slot:    pkhc_pkg::ESLOT_W'(r_eslot),
                           removed_total: pkhc_pkg::CNT_W'(r_removed),
                           live_count:    pkhc_pkg::CNT_W'(r_live)};

endmodule

`default_nettype wire
